### hdl/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared constants, character codes and the front-to-back command type of the
// visibility frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package vfr_pkg;

  localparam int BufDepth      = 64;
  localparam int PayloadOffset = 6;
  localparam int QueueDepth    = 2;

  localparam int AddrW = $clog2(BufDepth);
  localparam int IdxW  = $clog2(BufDepth + 1);
  localparam int PosW  = $clog2(BufDepth + PayloadOffset + 2) + 1;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam int VisW  = 16;
  localparam int StatW = 3;

  localparam int MinFrameLen = 5;
  localparam int TenSlashOff = 5;
  localparam int TenNumOff   = 6;
  localparam int OneSlashOff = 12;
  localparam int OneNumOff   = 13;
  localparam int StatOff     = 14;

  localparam logic [7:0] ChSoh   = 8'h01;
  localparam logic [7:0] ChEtx   = 8'h03;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ByteErased = 8'hFF;

  localparam logic [VisW-1:0]  VisMissing    = 16'hFFFF;
  localparam logic [VisW-1:0]  VisMax        = 16'hFFFE;
  localparam logic [StatW-1:0] StatusUnknown = 3'd5;

  typedef logic signed [PosW-1:0] pos_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [AddrW-1:0] addr;
    logic             parse;
    logic [IdxW-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/vfr_in_if.sv
// ----------------------------------------------------------------------------
// vfr_in_if
// Byte channel into the receiver: valid/ready handshake with one UART byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/vfr_out_if.sv
// ----------------------------------------------------------------------------
// vfr_out_if
// Result channel out of the receiver: valid/ready handshake with one decoded
// visibility record.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfr_out_if;
  import vfr_pkg::*;

  logic             valid;
  logic             ready;
  logic [VisW-1:0]  vis_one_min;
  logic [VisW-1:0]  vis_ten_min;
  logic [StatW-1:0] sensor_status;
  logic             data_ready;

  modport source (output valid, output vis_one_min, output vis_ten_min,
                  output sensor_status, output data_ready, input ready);
  modport sink   (input valid, input vis_one_min, input vis_ten_min,
                  input sensor_status, input data_ready, output ready);
endinterface

`default_nettype wire

### hdl/vfr_front.sv
// ----------------------------------------------------------------------------
// vfr_front
// Accepts bytes, tracks the write index, checks the header and detects the
// CR LF frame end. Each beat becomes one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vfr_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output vfr_pkg::cmd_t cmd_o
);
  import vfr_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      prev_q;
  logic            wrap;
  logic [IdxW-1:0] nidx;
  logic [IdxW-1:0] nafter;
  logic            hdr_fail;
  logic            parse;
  logic [7:0]      b;

  assign b        = in_i.rx_byte;
  assign in_i.ready = !q_full_i;
  assign push_o   = in_i.valid && !q_full_i;

  assign wrap = idx_q >= IdxW'(BufDepth);
  assign nidx = wrap ? IdxW'(1) : idx_q + IdxW'(1);

  assign hdr_fail = (nidx == IdxW'(1) && b != ChSoh) ||
                    (nidx == IdxW'(2) && b != ChP)   ||
                    (nidx == IdxW'(3) && b != ChW);
  assign nafter   = hdr_fail ? '0 : nidx;
  assign parse    = (b == ChLf) && (nafter > IdxW'(MinFrameLen)) && (prev_q == ChCr);
  assign idx_d    = parse ? '0 : nafter;

  always_comb begin
    cmd_o.data  = b;
    cmd_o.addr  = wrap ? '0 : idx_q[AddrW-1:0];
    cmd_o.parse = parse;
    cmd_o.len   = nafter;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      prev_q <= '0;
    end else if (push_o) begin
      idx_q  <= idx_d;
      prev_q <= b;
    end
  end

endmodule

`default_nettype wire

### hdl/vfr_queue.sv
// ----------------------------------------------------------------------------
// vfr_queue
// Short command FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vfr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output vfr_pkg::cmd_t cmd_o
);
  import vfr_pkg::*;

  cmd_t             entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

`default_nettype wire

### hdl/vfr_back.sv
// ----------------------------------------------------------------------------
// vfr_back
// Owns the frame buffer. Stores each byte and, on a frame end, scans for ETX;
// if found, reads the visibility fields and status digit, erases the frame and
// emits the result into an output register (without ETX it only erases).
// ----------------------------------------------------------------------------
`default_nettype none

module vfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  vfr_pkg::cmd_t cmd_i,
  output logic          pop_o,
  vfr_out_if.source     out_o
);
  import vfr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_FETCH    = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_CHK = 10'b0000001000,
    S_TEN_SL   = 10'b0000010000,
    S_DEC      = 10'b0000100000,
    S_ONE_SL   = 10'b0001000000,
    S_STAT     = 10'b0010000000,
    S_CLEAR    = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [7:0]         mem_q [BufDepth];
  logic [BufDepth-1:0] valid_q;
  logic [7:0]         rdata_q;
  logic               rvld_q, rin_q;

  pos_t             pos_q, pos_d, lim_q, lim_d, e_q, e_d;
  logic [IdxW-1:0]  len_q, len_d;
  logic [VisW-1:0]  acc_q, acc_d, ten_q, ten_d, one_q, one_d;
  logic             neg_q, neg_d, dig_q, dig_d, sel_q, sel_d, found_q, found_d;
  logic [StatW-1:0] stat_q, stat_d;

  logic             ov_q, ov_d;
  logic [VisW-1:0]  o_one_q, o_one_d, o_ten_q, o_ten_d;
  logic [StatW-1:0] o_stat_q, o_stat_d;
  logic             o_dr_q, o_dr_d;

  logic             wr_go;
  pos_t             wr_pos;
  logic [7:0]       wr_data;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic             rd_go, rd_in;
  logic             clr;
  logic [7:0]       c;
  logic [VisW-1:0]  dec_val;

  function automatic logic in_range(pos_t p);
    return !p[PosW-1] && (p < pos_t'(BufDepth));
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return (ch >= ChZero) && (ch <= ChNine);
  endfunction

  function automatic logic is_ws(logic [7:0] ch);
    return (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
  endfunction

  function automatic logic [VisW-1:0] acc_step(logic [VisW-1:0] a, logic [7:0] ch);
    logic [VisW+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{VisW{1'b0}}, ch[3:0]};
    if (a >= VisMax) return a;
    if (t > (VisW+4)'(VisMax)) return VisMax;
    return t[VisW-1:0];
  endfunction

  // byte seen by the sequencer; unwritten entries read erased, outside reads 0
  assign c       = rin_q ? (rvld_q ? rdata_q : ByteErased) : 8'h00;
  assign dec_val = neg_q ? '0 : acc_q;
  assign mem_we  = wr_go && in_range(wr_pos);
  assign mem_wa  = wr_pos[AddrW-1:0];

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    pos_d    = pos_q;
    lim_d    = lim_q;
    e_d      = e_q;
    len_d    = len_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    dig_d    = dig_q;
    sel_d    = sel_q;
    ten_d    = ten_q;
    one_d    = one_q;
    stat_d   = stat_q;
    found_d  = found_q;
    ov_d     = ov_q;
    o_one_d  = o_one_q;
    o_ten_d  = o_ten_q;
    o_stat_d = o_stat_q;
    o_dr_d   = o_dr_q;
    pop_o    = 1'b0;
    wr_go    = 1'b0;
    wr_pos   = '0;
    wr_data  = '0;
    rd_go    = 1'b0;
    rd_in    = 1'b0;
    clr      = 1'b0;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          wr_go   = 1'b1;
          wr_pos  = pos_t'(cmd_i.addr);
          wr_data = cmd_i.data;
          if (cmd_i.parse) begin
            len_d   = cmd_i.len;
            pos_d   = pos_t'(PayloadOffset + 1);
            lim_d   = pos_t'(PayloadOffset + 1) + pos_t'(cmd_i.len);
            found_d = 1'b0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_FETCH: begin
        rd_go   = 1'b1;
        rd_in   = in_range(pos_q);
        state_d = ret_q;
      end
      S_SCAN_RD: begin
        if (pos_q >= pos_t'(BufDepth) || pos_q > lim_q) begin
          state_d = S_CLEAR;
        end else begin
          rd_go   = 1'b1;
          rd_in   = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (c == ChEtx) begin
          found_d = 1'b1;
          e_d     = pos_q;
          wr_go   = 1'b1;
          wr_pos  = pos_q;
          pos_d   = pos_q - pos_t'(TenSlashOff);
          ret_d   = S_TEN_SL;
          state_d = S_FETCH;
        end else begin
          pos_d   = pos_q + pos_t'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_TEN_SL: begin
        state_d = S_FETCH;
        if (c == ChSlash) begin
          ten_d  = VisMissing;
          wr_go  = 1'b1;
          wr_pos = e_q - pos_t'(TenNumOff);
          pos_d  = e_q - pos_t'(OneSlashOff);
          ret_d  = S_ONE_SL;
        end else begin
          pos_d = e_q - pos_t'(TenNumOff);
          acc_d = '0;
          neg_d = 1'b0;
          dig_d = 1'b0;
          sel_d = 1'b0;
          ret_d = S_DEC;
        end
      end
      S_ONE_SL: begin
        state_d = S_FETCH;
        if (c == ChSlash) begin
          one_d  = VisMissing;
          wr_go  = 1'b1;
          wr_pos = e_q - pos_t'(OneNumOff);
          pos_d  = e_q - pos_t'(StatOff);
          ret_d  = S_STAT;
        end else begin
          pos_d = e_q - pos_t'(OneNumOff);
          acc_d = '0;
          neg_d = 1'b0;
          dig_d = 1'b0;
          sel_d = 1'b1;
          ret_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_FETCH;
        if (!dig_q && is_ws(c)) begin
          pos_d = pos_q + pos_t'(1);
        end else if (!dig_q && (c == ChPlus || c == ChMinus)) begin
          neg_d = c == ChMinus;
          dig_d = 1'b1;
          pos_d = pos_q + pos_t'(1);
        end else if (is_digit(c)) begin
          acc_d = acc_step(acc_q, c);
          dig_d = 1'b1;
          pos_d = pos_q + pos_t'(1);
        end else if (!sel_q) begin
          ten_d  = dec_val;
          wr_go  = 1'b1;
          wr_pos = e_q - pos_t'(TenNumOff);
          pos_d  = e_q - pos_t'(OneSlashOff);
          ret_d  = S_ONE_SL;
        end else begin
          one_d  = dec_val;
          wr_go  = 1'b1;
          wr_pos = e_q - pos_t'(OneNumOff);
          pos_d  = e_q - pos_t'(StatOff);
          ret_d  = S_STAT;
        end
      end
      S_STAT: begin
        stat_d  = (c >= ChZero && c <= ChFour) ? c[StatW-1:0] : StatusUnknown;
        state_d = S_CLEAR;
      end
      S_CLEAR: begin
        clr     = 1'b1;
        state_d = found_q ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d     = 1'b1;
          o_one_d  = one_q;
          o_ten_d  = ten_q;
          o_stat_d = stat_q;
          o_dr_d   = ten_q != VisMissing;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= wr_data;
    if (rd_go) begin
      rdata_q <= mem_q[pos_q[AddrW-1:0]];
      rvld_q  <= valid_q[pos_q[AddrW-1:0]];
      rin_q   <= rd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr) begin
      for (int i = 0; i < BufDepth; i++) begin
        if (IdxW'(i) < len_q) valid_q[i] <= 1'b0;
      end
    end else if (mem_we) begin
      valid_q[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    lim_q    <= lim_d;
    e_q      <= e_d;
    len_q    <= len_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    dig_q    <= dig_d;
    sel_q    <= sel_d;
    ten_q    <= ten_d;
    one_q    <= one_d;
    stat_q   <= stat_d;
    found_q  <= found_d;
    o_one_q  <= o_one_d;
    o_ten_q  <= o_ten_d;
    o_stat_q <= o_stat_d;
    o_dr_q   <= o_dr_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.vis_one_min   = o_one_q;
  assign out_o.vis_ten_min   = o_ten_q;
  assign out_o.sensor_status = o_stat_q;
  assign out_o.data_ready    = o_dr_q;

endmodule

`default_nettype wire

### hdl/visibility_frame_receiver.sv
// ----------------------------------------------------------------------------
// visibility_frame_receiver
// Collects sensor frames byte by byte and decodes the visibility record.
// ----------------------------------------------------------------------------
// A byte beat is taken whenever the two-entry command queue has room; the back
// end stores it when it pops it from the queue in idle. On a CR LF frame end
// the back end scans the frame buffer for ETX, reading and then checking each
// position (one buffer read port, registered), up to BufDepth - PayloadOffset - 1
// positions. If ETX is found it reads the two visibility fields and the status
// digit, fetching each byte before using it, erases the frame through per-entry
// valid bits, and loads the result register; without ETX it only erases.
// Ordinary bytes are stored while idle; during a frame end incoming bytes wait
// in the queue. No clearing pass is needed after reset.
`default_nettype none

module visibility_frame_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  vfr_in_if.sink    in_i,
  vfr_out_if.source out_o
);
  import vfr_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic push, pop, q_full, q_empty;

  vfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  vfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (back_cmd)
  );

  vfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cmd_i   (back_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### hdl/vfr_checker.sv
// ----------------------------------------------------------------------------
// vfr_checker
// Port-level checks on the result channel of the receiver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vfr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [vfr_pkg::VisW-1:0]  vis_one_min_i,
  input logic [vfr_pkg::VisW-1:0]  vis_ten_min_i,
  input logic [vfr_pkg::StatW-1:0] sensor_status_i,
  input logic                      data_ready_i
);
  import vfr_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({vis_one_min_i, vis_ten_min_i, sensor_status_i, data_ready_i}))
    else $error("stalled result beat changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sensor_status_i <= StatusUnknown)
    else $error("status code out of range");

  a_ready_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> data_ready_i == (vis_ten_min_i != VisMissing))
    else $error("data_ready disagrees with 10-minute value");

endmodule

bind visibility_frame_receiver vfr_checker u_vfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .vis_one_min_i   (out_o.vis_one_min),
  .vis_ten_min_i   (out_o.vis_ten_min),
  .sensor_status_i (out_o.sensor_status),
  .data_ready_i    (out_o.data_ready)
);

`default_nettype wire
